// ===== rtl/gsa_pkg.sv =====
`timescale 1ns / 1ps

package gsa_pkg;

  // internal score width, wide enough for every cell of a 32 by 32 matrix
  localparam int SCORE_W = 12;
  // widths of the result fields
  localparam int FSCORE_W = 11;
  localparam int ALEN_W   = 7;
  localparam int COL_W    = 6;

  // request kinds carried on the input tuser
  localparam logic [1:0] REQ_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] REQ_APPEND_SECOND = 2'd1;
  localparam logic [1:0] REQ_ALIGN         = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_GAP      = 2'd0;
  localparam logic [1:0] CFG_MATCH    = 2'd1;
  localparam logic [1:0] CFG_MISMATCH = 2'd2;

  typedef logic signed [SCORE_W-1:0] score_t;

  // traceback direction of one matrix cell
  typedef enum logic [1:0] {
    DIR_UP   = 2'd0,
    DIR_DIAG = 2'd1,
    DIR_LEFT = 2'd2
  } dir_t;

  typedef struct packed {
    logic [3:0]        gap;
    logic [3:0]        match;
    logic signed [4:0] mismatch;
  } cfg_t;

  typedef struct packed {
    score_t     up;
    score_t     diag;
    score_t     left;
    logic [1:0] sym_a;
    logic [1:0] sym_b;
  } cell_in_t;

  typedef struct packed {
    score_t best;
    dir_t   dir;
  } cell_out_t;

endpackage

// ===== rtl/global_sequence_aligner.sv =====
`timescale 1ns / 1ps
// channel  | dir | signals                              | carries
// s_axis   | in  | tvalid tready tdata[7:0] tuser[1:0]  | symbol, request kind
// m_axis   | out | tvalid tready tdata[23:0] tuser[1:0] | one alignment column per transfer
//          |     | tlast                                |
// cfg      | in  | valid ready index[1:0] data[4:0]     | register write, always ready
//
// an align fills the matrix one cell at a time through the shared cell unit and the
// score row ram (CELL_RD, CELL_EX), then traces back one column per TB_RD/TB_EX step
// and emits each column through EM_RD, EM_LD and EM_WAIT.
// rst is synchronous, active high, and clears lengths, flags, config and handshakes.
// the input is not ready from an align transfer until its last column is taken;
// a stalled output holds its column in the output register.

module global_sequence_aligner import gsa_pkg::*; #(
  parameter int MAX_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] symbol
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] first_symbol, [2] first_gap,
                                      // [4:3] second_symbol, [5] second_gap,
                                      // [16:6] final_score, [23:17] align_length
  output logic [1:0]  m_axis_tuser,   // [0] empty_res, [1] overflow
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int SEQ_AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TR_DEPTH  = (MAX_LEN + 1) * (MAX_LEN + 1);
  localparam int TR_AW     = $clog2(TR_DEPTH);
  localparam int COL_DEPTH = 2 * MAX_LEN;
  localparam int COL_AW    = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
  localparam int CNT_W     = $clog2(2 * MAX_LEN + 1);
  localparam logic [TR_AW-1:0] ROW_STEP  = TR_AW'(MAX_LEN + 1);
  localparam logic [TR_AW-1:0] DIAG_STEP = TR_AW'(MAX_LEN + 2);

  typedef enum logic [3:0] {
    IDLE,
    INIT,
    ROW_START,
    CELL_RD,
    CELL_EX,
    TB_RD,
    TB_EX,
    EM_RD,
    EM_LD,
    EM_WAIT
  } state_t;

  state_t            state;
  cfg_t              cfg;
  logic [LEN_W-1:0]  first_len;
  logic [LEN_W-1:0]  second_len;
  logic              ovf_flag;
  logic [LEN_W-1:0]  i_idx;
  logic [LEN_W-1:0]  j_idx;
  score_t            acc;
  score_t            col_acc;
  score_t            diag_q;
  score_t            left_q;
  score_t            score_q;
  logic [TR_AW-1:0]  row_base;
  logic [TR_AW-1:0]  taddr;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  align_len;
  logic [COL_W-1:0]  out_col;
  logic              out_empty;
  logic              out_ovf;

  score_t            gap_s;
  score_t            acc_next;
  score_t            col_acc_next;
  logic              in_xfer;

  // ram ports
  logic              first_we;
  logic              second_we;
  logic [SEQ_AW-1:0] seq_waddr;
  logic [SEQ_AW-1:0] first_raddr;
  logic [SEQ_AW-1:0] second_raddr;
  logic [1:0]        first_rdata;
  logic [1:0]        second_rdata;
  logic              score_we;
  score_t            score_wdata;
  score_t            score_rdata;
  logic              tr_we;
  logic [1:0]        tr_rdata;
  logic              col_we;
  logic [COL_W-1:0]  col_wdata;
  logic [COL_W-1:0]  col_rdata;

  cell_in_t          cin;
  cell_out_t         cout;

  // traceback step
  dir_t              tb_dir;
  logic [LEN_W-1:0]  i_next;
  logic [LEN_W-1:0]  j_next;
  logic [TR_AW-1:0]  taddr_next;

  assign s_axis_tready = (state == IDLE);
  assign cfg_ready     = 1'b1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {ALEN_W'(align_len), score_q[FSCORE_W-1:0], out_col};
  assign m_axis_tuser  = {out_ovf, out_empty};

  assign gap_s        = score_t'({{(SCORE_W-4){1'b0}}, cfg.gap});
  assign acc_next     = acc - gap_s;
  assign col_acc_next = col_acc - gap_s;

  // sequence stores
  assign first_we     = in_xfer && (s_axis_tuser == REQ_APPEND_FIRST) && (first_len < LEN_W'(MAX_LEN));
  assign second_we    = in_xfer && (s_axis_tuser == REQ_APPEND_SECOND)
                        && (second_len < LEN_W'(MAX_LEN));
  assign seq_waddr    = (s_axis_tuser == REQ_APPEND_FIRST) ? first_len[SEQ_AW-1:0]
                                                           : second_len[SEQ_AW-1:0];
  assign first_raddr  = SEQ_AW'(j_idx - LEN_W'(1));
  assign second_raddr = SEQ_AW'(i_idx - LEN_W'(1));

  gsa_ram #(.WIDTH(2), .DEPTH(MAX_LEN)) u_first_ram (
    .clk   (clk),
    .we    (first_we),
    .waddr (seq_waddr),
    .wdata (s_axis_tdata[1:0]),
    .raddr (first_raddr),
    .rdata (first_rdata)
  );

  gsa_ram #(.WIDTH(2), .DEPTH(MAX_LEN)) u_second_ram (
    .clk   (clk),
    .we    (second_we),
    .waddr (seq_waddr),
    .wdata (s_axis_tdata[1:0]),
    .raddr (second_raddr),
    .rdata (second_rdata)
  );

  // score row: border values while initializing, cell results while filling
  assign score_we    = (state == INIT) || (state == CELL_EX);
  assign score_wdata = (state == INIT) ? acc : cout.best;

  gsa_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_LEN + 1)) u_score_ram (
    .clk   (clk),
    .we    (score_we),
    .waddr (j_idx),
    .wdata (score_wdata),
    .raddr (j_idx),
    .rdata (score_rdata)
  );

  // shared cell unit
  assign cin.up    = score_rdata;
  assign cin.diag  = diag_q;
  assign cin.left  = left_q;
  assign cin.sym_a = first_rdata;
  assign cin.sym_b = second_rdata;

  gsa_cell u_cell (
    .cfg  (cfg),
    .cin  (cin),
    .cout (cout)
  );

  assign tr_we = (state == CELL_EX);

  gsa_ram #(.WIDTH(2), .DEPTH(TR_DEPTH)) u_trace_ram (
    .clk   (clk),
    .we    (tr_we),
    .waddr (taddr),
    .wdata (cout.dir),
    .raddr (taddr),
    .rdata (tr_rdata)
  );

  // traceback direction with border overrides, and the column it produces
  always_comb begin
    tb_dir = dir_t'(tr_rdata);
    if (i_idx == '0) begin
      tb_dir = DIR_LEFT;
    end
    if (j_idx == '0) begin
      tb_dir = DIR_UP;
    end
    case (tb_dir)
      DIR_UP: begin
        col_wdata  = {1'b0, second_rdata, 1'b1, 2'b00};
        i_next     = i_idx - LEN_W'(1);
        j_next     = j_idx;
        taddr_next = taddr - ROW_STEP;
      end
      DIR_DIAG: begin
        col_wdata  = {1'b0, second_rdata, 1'b0, first_rdata};
        i_next     = i_idx - LEN_W'(1);
        j_next     = j_idx - LEN_W'(1);
        taddr_next = taddr - DIAG_STEP;
      end
      default: begin
        col_wdata  = {1'b1, 2'b00, 1'b0, first_rdata};
        i_next     = i_idx;
        j_next     = j_idx - LEN_W'(1);
        taddr_next = taddr - TR_AW'(1);
      end
    endcase
  end

  assign col_we = (state == TB_EX);

  gsa_ram #(.WIDTH(COL_W), .DEPTH(COL_DEPTH)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (cnt[COL_AW-1:0]),
    .wdata (col_wdata),
    .raddr (rd_ptr[COL_AW-1:0]),
    .rdata (col_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap      <= 4'd2;
      cfg.match    <= 4'd2;
      cfg.mismatch <= -5'sd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GAP:      cfg.gap      <= cfg_data[3:0];
        CFG_MATCH:    cfg.match    <= cfg_data[3:0];
        CFG_MISMATCH: cfg.mismatch <= cfg_data;
        default:      ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      first_len     <= '0;
      second_len    <= '0;
      ovf_flag      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_xfer) begin
            case (s_axis_tuser)
              REQ_APPEND_FIRST: begin
                if (first_we) begin
                  first_len <= first_len + LEN_W'(1);
                end else begin
                  ovf_flag <= 1'b1;
                end
              end
              REQ_APPEND_SECOND: begin
                if (second_we) begin
                  second_len <= second_len + LEN_W'(1);
                end else begin
                  ovf_flag <= 1'b1;
                end
              end
              REQ_ALIGN: begin
                out_ovf   <= ovf_flag;
                ovf_flag  <= 1'b0;
                i_idx     <= '0;
                j_idx     <= '0;
                acc       <= '0;
                col_acc   <= '0;
                row_base  <= '0;
                cnt       <= '0;
                if (first_len == '0 && second_len == '0) begin
                  out_empty     <= 1'b1;
                  out_col       <= '0;
                  score_q       <= '0;
                  align_len     <= '0;
                  rd_ptr        <= '0;
                  m_axis_tlast  <= 1'b1;
                  m_axis_tvalid <= 1'b1;
                  state         <= EM_WAIT;
                end else begin
                  out_empty <= 1'b0;
                  state     <= INIT;
                end
              end
              default: ;
            endcase
          end
        end
        // first row: score_row[j] = -j * gap
        INIT: begin
          score_q <= acc;
          if (j_idx == first_len) begin
            if (second_len == '0) begin
              taddr <= TR_AW'(first_len);
              state <= TB_RD;
            end else begin
              i_idx <= LEN_W'(1);
              state <= ROW_START;
            end
          end else begin
            j_idx <= j_idx + LEN_W'(1);
            acc   <= acc_next;
          end
        end
        // first column cell of a row is kept in a register only
        ROW_START: begin
          row_base <= row_base + ROW_STEP;
          col_acc  <= col_acc_next;
          diag_q   <= col_acc;
          left_q   <= col_acc_next;
          if (first_len == '0) begin
            score_q <= col_acc_next;
            j_idx   <= '0;
            if (i_idx == second_len) begin
              taddr <= row_base + ROW_STEP;
              state <= TB_RD;
            end else begin
              i_idx <= i_idx + LEN_W'(1);
            end
          end else begin
            j_idx <= LEN_W'(1);
            taddr <= row_base + ROW_STEP + TR_AW'(1);
            state <= CELL_RD;
          end
        end
        CELL_RD: begin
          state <= CELL_EX;
        end
        CELL_EX: begin
          diag_q  <= score_rdata;
          left_q  <= cout.best;
          score_q <= cout.best;
          if (j_idx == first_len) begin
            if (i_idx == second_len) begin
              state <= TB_RD;
            end else begin
              i_idx <= i_idx + LEN_W'(1);
              state <= ROW_START;
            end
          end else begin
            j_idx <= j_idx + LEN_W'(1);
            taddr <= taddr + TR_AW'(1);
            state <= CELL_RD;
          end
        end
        TB_RD: begin
          state <= TB_EX;
        end
        // one column per step, stored in reverse order
        TB_EX: begin
          i_idx <= i_next;
          j_idx <= j_next;
          taddr <= taddr_next;
          cnt   <= cnt + CNT_W'(1);
          if (i_next == '0 && j_next == '0) begin
            rd_ptr    <= cnt;
            align_len <= cnt + CNT_W'(1);
            state     <= EM_RD;
          end else begin
            state <= TB_RD;
          end
        end
        EM_RD: begin
          state <= EM_LD;
        end
        EM_LD: begin
          out_col       <= col_rdata;
          m_axis_tlast  <= (rd_ptr == '0);
          m_axis_tvalid <= 1'b1;
          state         <= EM_WAIT;
        end
        EM_WAIT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (m_axis_tlast) begin
              first_len  <= '0;
              second_len <= '0;
              state      <= IDLE;
            end else begin
              rd_ptr <= rd_ptr - CNT_W'(1);
              state  <= EM_RD;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // no input transfer while a column waits on the output
  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while an output column is pending");

  // the empty result is a run of one
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("empty result not marked last");

  // a column of a non-empty run reports a nonzero length
  a_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[23:17] != '0))
    else $error("column with zero alignment length");

  // the block is ready again right after the final column transfer
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready after final column");

endmodule

// ===== rtl/gsa_ram.sv =====
`timescale 1ns / 1ps

module gsa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gsa_cell.sv =====
`timescale 1ns / 1ps

module gsa_cell import gsa_pkg::*; (
  input  cfg_t      cfg,
  input  cell_in_t  cin,
  output cell_out_t cout
);

  score_t gap_s;
  score_t sub_s;
  score_t fu;
  score_t fd;
  score_t fl;

  // substitution score and the three candidates
  assign gap_s = score_t'({{(SCORE_W-4){1'b0}}, cfg.gap});
  assign sub_s = (cin.sym_a == cin.sym_b) ? score_t'({{(SCORE_W-4){1'b0}}, cfg.match})
                                          : score_t'({{(SCORE_W-5){cfg.mismatch[4]}},
                                                      cfg.mismatch});
  assign fu = cin.up - gap_s;
  assign fd = cin.diag + sub_s;
  assign fl = cin.left - gap_s;

  // up wins ties, diag must beat left strictly
  always_comb begin
    if (fu >= fd && fu >= fl) begin
      cout.best = fu;
      cout.dir  = DIR_UP;
    end else if (fd > fl) begin
      cout.best = fd;
      cout.dir  = DIR_DIAG;
    end else begin
      cout.best = fl;
      cout.dir  = DIR_LEFT;
    end
  end

endmodule
